// ===== hdl/qrs_pkg.sv =====
// Shared constants for the quadratic root solver.
package qrs_pkg;

  // Width of each signed fixed-point root on the result stream.
  localparam int unsigned RootWidth = 48;

  // Root count codes.
  localparam logic [1:0] CntNone = 2'd0;
  localparam logic [1:0] CntOne  = 2'd1;
  localparam logic [1:0] CntTwo  = 2'd2;

endpackage

// ===== hdl/qrs_sqrt_cell.sv =====
// One cell of the square root chain: decides one root bit per stage.
module qrs_sqrt_cell #(
  parameter int unsigned DW  = 35,
  parameter int unsigned SW  = 18,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [SW-1:0] root_i,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] root_o
);

  localparam int unsigned TW = 2 * SW + 2;

  logic [TW-1:0] term;
  logic [TW-1:0] rem_x;
  logic          fits;
  logic [DW-1:0] rem_d;
  logic [SW-1:0] root_d;

  // Growth of the square when this bit is set: 2*root*2^BIT + 2^(2*BIT).
  always_comb begin
    term   = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    rem_x  = TW'(rem_i);
    fits   = (term <= rem_x);
    rem_d  = fits ? DW'(rem_x - term) : rem_i;
    root_d = fits ? (root_i | (SW'(1) << BIT)) : root_i;
  end

  // Hand the partial remainder and root to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

// ===== hdl/qrs_div_cell.sv =====
// One cell of the restoring divider chain: decides one quotient bit per stage.
module qrs_div_cell #(
  parameter int unsigned QW  = 37,
  parameter int unsigned DNW = 17,
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [QW-1:0]  num_i,
  input  logic [DNW-1:0] den_i,
  input  logic [DNW-1:0] rem_i,
  input  logic [QW-1:0]  quo_i,
  output logic [QW-1:0]  num_o,
  output logic [DNW-1:0] den_o,
  output logic [DNW-1:0] rem_o,
  output logic [QW-1:0]  quo_o
);

  logic [DNW:0]   trial;
  logic           fits;
  logic [DNW-1:0] rem_d;
  logic [QW-1:0]  quo_d;

  // Bring down the next numerator bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_i, num_i[BIT]};
    fits  = (trial >= {1'b0, den_i});
    rem_d = fits ? DNW'(trial - {1'b0, den_i}) : trial[DNW-1:0];
    quo_d = fits ? (quo_i | (QW'(1) << BIT)) : quo_i;
  end

  // Pass operands and partial results to the next cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o <= num_i;
      den_o <= den_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
    end
  end

endmodule

// ===== hdl/quadratic_root_solver.sv =====
// Quadratic real-root solver: discriminant, square root chain and divider chains.
// Pipeline: two front stages, COEF_WIDTH + 2 root cells, one numerator stage,
// COEF_WIDTH + FRAC_BITS + 3 quotient cells and the output register.
// Throughput: one equation per cycle; the whole pipeline holds while an output beat waits.
// Reset: rst_ni clears all valid flags asynchronously; data registers are not reset.
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // coef_a, coef_b, coef_c from the lowest bit up
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // root_count, root_first, root_second from the lowest bit up
  output logic [((2+2*RootWidth+7)/8)*8-1:0]           m_axis_tdata
);

  localparam int unsigned CW    = COEF_WIDTH;
  localparam int unsigned OW    = ((2 + 2 * RootWidth + 7) / 8) * 8;
  localparam int unsigned DW    = 2 * CW + 3;
  localparam int unsigned SW    = CW + 2;
  localparam int unsigned NW    = CW + 3;
  localparam int unsigned DNW   = CW + 1;
  localparam int unsigned QW    = NW + FRAC_BITS;
  localparam int unsigned LW    = ((QW > RootWidth) ? QW : RootWidth) + 1;
  localparam int unsigned NSTG  = SW + QW + 4;

  typedef struct packed {
    logic signed [CW-1:0] b;
    logic [DNW-1:0]       den;
    logic                 den_neg;
    logic [1:0]           count;
    logic [NW-1:0]        n1_mag;
    logic                 n1_neg;
  } pre_t;

  typedef struct packed {
    logic [1:0] count;
    logic       neg1;
    logic       neg2;
  } post_t;

  logic            en;
  logic [NSTG-1:0] vld_q;

  // Global advance: the pipeline moves whenever the output register is free or taken.
  assign en            = ~vld_q[NSTG-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSTG-1];

  // Valid flags travel with their beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: magnitudes and the two products.
  logic signed [CW-1:0] a_in, b_in, c_in;
  logic [CW-1:0]        a_mag, b_mag, c_mag;
  logic signed [CW-1:0] a_q, b_q, c_q;
  logic [2*CW-1:0]      bb_q, ac_q;

  assign a_in  = s_axis_tdata[CW-1:0];
  assign b_in  = s_axis_tdata[2*CW-1:CW];
  assign c_in  = s_axis_tdata[3*CW-1:2*CW];
  assign a_mag = a_in[CW-1] ? (~a_in + 1'b1) : a_in;
  assign b_mag = b_in[CW-1] ? (~b_in + 1'b1) : b_in;
  assign c_mag = c_in[CW-1] ? (~c_in + 1'b1) : c_in;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= a_in;
      b_q  <= b_in;
      c_q  <= c_in;
      bb_q <= b_mag * b_mag;
      ac_q <= a_mag * c_mag;
    end
  end

  // Stage 2: discriminant, root count and the single-root operands.
  logic [DW-1:0] bb_x, ac4_x, disc;
  logic          ac_pos, disc_neg;
  logic [CW-1:0] a_mag1, b_mag1, c_mag1;
  pre_t          pre_d;
  logic [DW-1:0] disc_q;
  pre_t          pre_pipe [SW+1];

  assign a_mag1 = a_q[CW-1] ? (~a_q + 1'b1) : a_q;
  assign b_mag1 = b_q[CW-1] ? (~b_q + 1'b1) : b_q;
  assign c_mag1 = c_q[CW-1] ? (~c_q + 1'b1) : c_q;

  always_comb begin
    bb_x   = DW'(bb_q);
    ac4_x  = DW'(ac_q) << 2;
    ac_pos = (c_q != '0) && (a_q[CW-1] == c_q[CW-1]);
    disc_neg = 1'b0;
    if (!ac_pos) begin
      disc = bb_x + ac4_x;
    end else if (ac4_x > bb_x) begin
      disc     = '0;
      disc_neg = 1'b1;
    end else begin
      disc = bb_x - ac4_x;
    end

    pre_d.b = b_q;
    if (a_q == '0) begin
      pre_d.den     = DNW'(b_mag1);
      pre_d.den_neg = b_q[CW-1];
      pre_d.count   = (b_q != '0) ? CntOne : CntNone;
      pre_d.n1_mag  = NW'(c_mag1);
      pre_d.n1_neg  = ~c_q[CW-1] && (c_q != '0);
    end else begin
      pre_d.den     = DNW'(a_mag1) << 1;
      pre_d.den_neg = a_q[CW-1];
      pre_d.count   = disc_neg ? CntNone : ((disc != '0) ? CntTwo : CntOne);
      pre_d.n1_mag  = NW'(b_mag1);
      pre_d.n1_neg  = ~b_q[CW-1] && (b_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc_q      <= disc;
      pre_pipe[0] <= pre_d;
    end
  end

  // Square root chain, most significant root bit first.
  logic [DW-1:0] srem [SW+1];
  logic [SW-1:0] sroot [SW+1];

  assign srem[0]  = disc_q;
  assign sroot[0] = '0;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(
      .DW  (DW),
      .SW  (SW),
      .BIT (SW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (srem[k]),
      .root_i (sroot[k]),
      .rem_o  (srem[k+1]),
      .root_o (sroot[k+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        pre_pipe[k+1] <= pre_pipe[k];
      end
    end
  end

  // Stage after the root: numerators and quotient signs.
  pre_t                 pre_s;
  logic signed [NW-1:0] bx, sx, np, nm;
  logic [NW-1:0]        np_mag, nm_mag, num1_mag;
  post_t                post_d;
  logic [QW-1:0]        num1_q, num2_q;
  logic [DNW-1:0]       den_q;
  post_t                post_pipe [QW+1];

  assign pre_s = pre_pipe[SW];

  always_comb begin
    bx     = NW'(pre_s.b);
    sx     = NW'(sroot[SW]);
    np     = sx - bx;
    nm     = -bx - sx;
    np_mag = np[NW-1] ? (~np + 1'b1) : np;
    nm_mag = nm[NW-1] ? (~nm + 1'b1) : nm;
    post_d.count = pre_s.count;
    if (pre_s.count == CntTwo) begin
      num1_mag    = np_mag;
      post_d.neg1 = np[NW-1] ^ pre_s.den_neg;
    end else begin
      num1_mag    = pre_s.n1_mag;
      post_d.neg1 = pre_s.n1_neg ^ pre_s.den_neg;
    end
    post_d.neg2 = nm[NW-1] ^ pre_s.den_neg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q       <= {num1_mag, {FRAC_BITS{1'b0}}};
      num2_q       <= {nm_mag, {FRAC_BITS{1'b0}}};
      den_q        <= pre_s.den;
      post_pipe[0] <= post_d;
    end
  end

  // Two divider chains, one per root.
  logic [QW-1:0]  n1 [QW+1], n2 [QW+1], q1 [QW+1], q2 [QW+1];
  logic [DNW-1:0] d1 [QW+1], d2 [QW+1], r1 [QW+1], r2 [QW+1];

  assign n1[0] = num1_q;
  assign n2[0] = num2_q;
  assign d1[0] = den_q;
  assign d2[0] = den_q;
  assign r1[0] = '0;
  assign r2[0] = '0;
  assign q1[0] = '0;
  assign q2[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    qrs_div_cell #(
      .QW  (QW),
      .DNW (DNW),
      .BIT (QW - 1 - k)
    ) u_first (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (n1[k]),
      .den_i (d1[k]),
      .rem_i (r1[k]),
      .quo_i (q1[k]),
      .num_o (n1[k+1]),
      .den_o (d1[k+1]),
      .rem_o (r1[k+1]),
      .quo_o (q1[k+1])
    );

    qrs_div_cell #(
      .QW  (QW),
      .DNW (DNW),
      .BIT (QW - 1 - k)
    ) u_second (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (n2[k]),
      .den_i (d2[k]),
      .rem_i (r2[k]),
      .quo_i (q2[k]),
      .num_o (n2[k+1]),
      .den_o (d2[k+1]),
      .rem_o (r2[k+1]),
      .quo_o (q2[k+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        post_pipe[k+1] <= post_pipe[k];
      end
    end
  end

  // Output stage: sign, saturation and masking of unused roots.
  localparam logic [LW-1:0] Lim = LW'(1) << (RootWidth - 1);

  post_t                 post_s;
  logic [LW-1:0]         q1x, q2x, v1, v2;
  logic [RootWidth-1:0]  root1_d, root2_d;
  logic [1:0]            cnt_q;
  logic [RootWidth-1:0]  root1_q, root2_q;

  assign post_s = post_pipe[QW];

  always_comb begin
    q1x = LW'(q1[QW]);
    q2x = LW'(q2[QW]);
    if (post_s.neg1) begin
      v1 = (q1x > Lim) ? Lim : q1x;
      v1 = -v1;
    end else begin
      v1 = (q1x > Lim - 1'b1) ? (Lim - 1'b1) : q1x;
    end
    if (post_s.neg2) begin
      v2 = (q2x > Lim) ? Lim : q2x;
      v2 = -v2;
    end else begin
      v2 = (q2x > Lim - 1'b1) ? (Lim - 1'b1) : q2x;
    end
    root1_d = (post_s.count != CntNone) ? v1[RootWidth-1:0] : '0;
    root2_d = (post_s.count == CntTwo) ? v2[RootWidth-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_q   <= post_s.count;
      root1_q <= root1_d;
      root2_q <= root2_d;
    end
  end

  assign m_axis_tdata = OW'({root2_q, root1_q, cnt_q});

  // Checks on the result stream and the stall logic.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cnt_q == CntNone) |-> (root1_q == '0) && (root2_q == '0))
    else $error("root fields set with no roots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt_q == CntNone) || (cnt_q == CntOne) || (cnt_q == CntTwo))
    else $error("bad root count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cnt_q != CntTwo) |-> (root2_q == '0))
    else $error("second root set without two roots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(root1_q))
    else $error("stalled result changed");

endmodule

// ===== tb/quadratic_root_solver_tb.sv =====
// Testbench for the quadratic root solver: random and corner equations checked against a predictor.
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int IN_W = ((3*CW+7)/8)*8;
  localparam int OUT_W = ((2+2*RootWidth+7)/8)*8;
  localparam int LATENCY = 2 * CW + FB + 9;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]            cnt;
    logic [RootWidth-1:0]  first;
    logic [RootWidth-1:0]  second;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  quadratic_root_solver dut (.*);

  logic [IN_W-1:0] coef_queue[$];
  roots_t expected_roots[$];
  int mismatches = 0;
  int cycles = 0;
  bit stimulus_done = 0;
  bit hold_sender = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // Fixed-point quotient (num << FB) / den, truncated toward zero and saturated.
  function automatic logic [RootWidth-1:0] fixed_div(longint signed num, longint signed den);
    logic [127:0] nmag, dmag, q, lim;
    bit neg;
    if (den == 0) return '0;
    neg = (num < 0) != (den < 0);
    nmag = num < 0 ? -num : num;
    dmag = den < 0 ? -den : den;
    q = (nmag << FB) / dmag;
    lim = 128'd1 << (RootWidth - 1);
    if (neg) begin
      if (q > lim) q = lim;
      return -q[RootWidth-1:0];
    end
    if (q > lim - 1) q = lim - 1;
    return q[RootWidth-1:0];
  endfunction

  // Floor square root of a nonnegative discriminant.
  function automatic longint isqrt(logic signed [127:0] d);
    logic [127:0] r, cand;
    r = 0;
    for (int bitpos = 40; bitpos >= 0; bitpos--) begin
      cand = r | (128'd1 << bitpos);
      if (cand * cand <= d) r = cand;
    end
    return longint'(r);
  endfunction

  // Roots of a*x^2 + b*x + c = 0.
  function automatic roots_t solve_roots(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                         logic signed [CW-1:0] c);
    roots_t r;
    logic signed [127:0] disc;
    longint s, la, lb, lc;
    r = '0;
    la = a; lb = b; lc = c;
    if (la == 0) begin
      if (lb != 0) begin
        r.cnt = CntOne;
        r.first = fixed_div(-lc, lb);
      end
    end else begin
      disc = 128'(lb) * lb - 128'(4) * la * lc;
      if (disc > 0) begin
        s = isqrt(disc);
        r.cnt = CntTwo;
        r.first = fixed_div(-lb + s, 2 * la);
        r.second = fixed_div(-lb - s, 2 * la);
      end else if (disc == 0) begin
        r.cnt = CntOne;
        r.first = fixed_div(-lb, 2 * la);
      end
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_coefs(int a, int b, int c);
    logic [IN_W-1:0] w;
    w = '0;
    w[CW-1:0] = a[CW-1:0];
    w[2*CW-1:CW] = b[CW-1:0];
    w[3*CW-1:2*CW] = c[CW-1:0];
    return w;
  endfunction

  function automatic int rnd_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return $urandom_range(0, 64) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Stimulus: directed corners, then random equations with a drain pause midway.
  initial begin
    int ext[5];
    int r;
    ext = '{-32768, -1, 0, 1, 32767};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    coef_queue.push_back(pack_coefs(0, 0, 5));
    coef_queue.push_back(pack_coefs(0, 0, 0));
    coef_queue.push_back(pack_coefs(0, 3, 0));
    coef_queue.push_back(pack_coefs(0, -7, 22));
    coef_queue.push_back(pack_coefs(1, -5, 6));
    coef_queue.push_back(pack_coefs(1, 2, 1));
    coef_queue.push_back(pack_coefs(1, 0, 1));
    coef_queue.push_back(pack_coefs(2, 4, 0));
    coef_queue.push_back(pack_coefs(-3, 0, 12));
    coef_queue.push_back(pack_coefs(0, 1, -32768));
    coef_queue.push_back(pack_coefs(0, -1, -32768));
    coef_queue.push_back(pack_coefs(1000, 1, 1));
    for (int i = 0; i < 13; i++)
      coef_queue.push_back(pack_coefs(ext[i % 5], ext[(i / 5 + i) % 5], ext[(i * 3 + 1) % 5]));
    for (int i = 0; i < 200; i++)
      coef_queue.push_back(pack_coefs(rnd_coef(), rnd_coef(), rnd_coef()));
    wait (coef_queue.size() == 0);
    hold_sender = 1;
    wait (!s_axis_tvalid && expected_roots.size() == 0);
    hold_sender = 0;
    for (int i = 0; i < 200; i++) begin
      r = rnd_coef();
      coef_queue.push_back(pack_coefs(r, rnd_coef(), rnd_coef()));
    end
    wait (coef_queue.size() == 0 && !s_axis_tvalid);
    stimulus_done = 1;
  end

  // Driver: one beat per queued item, with a random gap after each.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_roots.push_back(solve_roots(s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                                             s_axis_tdata[3*CW-1:2*CW]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (coef_queue.size() > 0 && !hold_sender) begin
          s_axis_tdata <= coef_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat and apply random back-pressure.
  always @(posedge clk_i) begin
    roots_t got, want;
    int gap;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cnt = m_axis_tdata[1:0];
        got.first = m_axis_tdata[2+RootWidth-1:2];
        got.second = m_axis_tdata[2+2*RootWidth-1:2+RootWidth];
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: %p", got);
        end else begin
          want = expected_roots.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected cnt=%0d r1=%h r2=%h, got cnt=%0d r1=%h r2=%h",
                       want.cnt, want.first, want.second, got.cnt, got.first, got.second);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && m_axis_tvalid) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          recv_gap <= gap - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Cycle watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // End of run: drain, let the pipeline settle, then report.
  initial begin
    wait (stimulus_done);
    wait (expected_roots.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
